### src/osdf_pkg.sv
// Shared types, codes and constants of the oscillating spring-damper force block.
`timescale 1ns / 1ps
package osdf_pkg;

    localparam int FRAC_BITS_DEF = 16;

    // Iterative unit widths: radicand, second operand, product, remainder.
    localparam int A_W = 66;
    localparam int B_W = 33;
    localparam int P_W = 80;
    localparam int R_W = 36;
    localparam int CNT_W = 6;
    localparam int ROOT_STEPS = 33;
    localparam int DIV_STEPS = 31;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 31;

    localparam logic [CFG_IDX_W-1:0] REG_CLOCK_START     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLOCK_STEP      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CONTRACT_TIME   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EXPAND_LENGTH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CONTRACT_LENGTH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STIFFNESS       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DAMPING         = 3'd6;

    localparam logic [15:0] RST_CLOCK_STEP      = 16'd655;
    localparam logic [15:0] RST_CONTRACT_TIME   = 16'd32768;
    localparam logic [30:0] RST_EXPAND_LENGTH   = 31'd1310720;
    localparam logic [30:0] RST_CONTRACT_LENGTH = 31'd655360;
    localparam logic [15:0] RST_STIFFNESS       = 16'd256;
    localparam logic [15:0] RST_DAMPING         = 16'd26;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_SQRT,
        OP_DIV
    } unit_op_t;

    typedef struct packed {
        logic           start;
        unit_op_t       op;
        logic [A_W-1:0] a;
        logic [B_W-1:0] b;
    } unit_req_t;

    typedef struct packed {
        logic           busy;
        logic           done;
        logic [P_W-1:0] res;
    } unit_rsp_t;

    typedef struct packed {
        logic [15:0] stiffness;
        logic [15:0] damping;
        logic [30:0] expand_length;
        logic [30:0] contract_length;
        logic [15:0] phase;
        logic        contracted;
    } osc_t;

endpackage

### src/osdf_osc.sv
// Configuration registers and the oscillator phase state.
`timescale 1ns / 1ps
module osdf_osc (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [osdf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [osdf_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               tick,
    output osdf_pkg::osc_t                     osc
);
    import osdf_pkg::*;

    logic [15:0] step_reg;
    logic [15:0] ctime_reg;
    logic [30:0] exp_reg;
    logic [30:0] con_reg;
    logic [15:0] stiff_reg;
    logic [15:0] damp_reg;
    logic [15:0] phase_reg;
    logic        contracted_reg;
    logic [16:0] phase_sum;
    logic [15:0] phase_next;

    // The phase wraps to zero once it reaches one.
    assign phase_sum  = {1'b0, phase_reg} + {1'b0, step_reg};
    assign phase_next = phase_sum[16] ? 16'd0 : phase_sum[15:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg       <= RST_CLOCK_STEP;
            ctime_reg      <= RST_CONTRACT_TIME;
            exp_reg        <= RST_EXPAND_LENGTH;
            con_reg        <= RST_CONTRACT_LENGTH;
            stiff_reg      <= RST_STIFFNESS;
            damp_reg       <= RST_DAMPING;
            phase_reg      <= 16'd0;
            contracted_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_CLOCK_START:     phase_reg <= cfg_data[15:0];
                    REG_CLOCK_STEP:      step_reg  <= cfg_data[15:0];
                    REG_CONTRACT_TIME:   ctime_reg <= cfg_data[15:0];
                    REG_EXPAND_LENGTH:   exp_reg   <= cfg_data[30:0];
                    REG_CONTRACT_LENGTH: con_reg   <= cfg_data[30:0];
                    REG_STIFFNESS:       stiff_reg <= cfg_data[15:0];
                    REG_DAMPING:         damp_reg  <= cfg_data[15:0];
                    default:             ;
                endcase
            end
            if (tick)
            begin
                phase_reg      <= phase_next;
                contracted_reg <= (phase_next > ctime_reg);
            end
        end
    end

    assign osc.stiffness       = stiff_reg;
    assign osc.damping         = damp_reg;
    assign osc.expand_length   = exp_reg;
    assign osc.contract_length = con_reg;
    assign osc.phase           = phase_reg;
    assign osc.contracted      = contracted_reg;

endmodule

### src/osdf_unit.sv
// Shared bit-serial unit: shift-add multiply, restoring square root and division.
`timescale 1ns / 1ps
module osdf_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  osdf_pkg::unit_req_t  req,
    output osdf_pkg::unit_rsp_t  rsp
);
    import osdf_pkg::*;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    unit_op_t         op_reg, op_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [P_W-1:0]   x_reg, x_next;
    logic [B_W-1:0]   y_reg, y_next;
    logic [P_W-1:0]   acc_reg, acc_next;
    logic [R_W-1:0]   rem_reg, rem_next;
    logic [R_W-1:0]   rem_sh;
    logic [R_W-1:0]   trial;
    logic [R_W-1:0]   divisor;

    assign rem_sh  = {rem_reg[R_W-3:0], x_reg[A_W-1:A_W-2]};
    assign trial   = {acc_reg[R_W-3:0], 2'b01};
    assign divisor = R_W'(y_reg);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        if (!busy_reg)
        begin
            if (req.start)
            begin
                busy_next = 1'b1;
                op_next   = req.op;
                x_next    = P_W'(req.a);
                y_next    = req.b;
                acc_next  = '0;
                rem_next  = (req.op == OP_DIV) ? R_W'(req.a[B_W-1:0]) : '0;
                cnt_next  = (req.op == OP_SQRT) ? CNT_W'(ROOT_STEPS) : CNT_W'(DIV_STEPS);
            end
        end
        else
        begin
            case (op_reg)
                OP_MUL:
                begin
                    // Ends as soon as no multiplier bits remain.
                    if (y_reg == '0)
                    begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        if (y_reg[0])
                        begin
                            acc_next = acc_reg + x_reg;
                        end
                        x_next = x_reg << 1;
                        y_next = y_reg >> 1;
                    end
                end
                OP_SQRT:
                begin
                    if (rem_sh >= trial)
                    begin
                        rem_next = rem_sh - trial;
                        acc_next = {acc_reg[P_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = rem_sh;
                        acc_next = {acc_reg[P_W-2:0], 1'b0};
                    end
                    x_next   = x_reg << 2;
                    cnt_next = cnt_reg - CNT_W'(1);
                    if (cnt_reg == CNT_W'(1))
                    begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                end
                OP_DIV:
                begin
                    if (rem_reg >= divisor)
                    begin
                        rem_next = (rem_reg - divisor) << 1;
                        acc_next = {acc_reg[P_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = rem_reg << 1;
                        acc_next = {acc_reg[P_W-2:0], 1'b0};
                    end
                    cnt_next = cnt_reg - CNT_W'(1);
                    if (cnt_reg == CNT_W'(1))
                    begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                end
                default:
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        cnt_reg <= cnt_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        acc_reg <= acc_next;
        rem_reg <= rem_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.res  = acc_reg;

endmodule

### src/oscillating_spring_damper_force.sv
// Top level of the oscillating spring-damper force block: sequencer and output word.
// A tick word skips the arithmetic and passes through the done state to the output register;
// a force word is worked by the shared bit-serial unit (one bit per cycle over two squares,
// a 33-step root, two 31-step divisions and six multiplies that stop on zero multiplier).
// One word is in work at a time; the next is taken once the result reaches the output register.
// Reset clears the oscillator phase and contracted flag and loads register defaults.
`timescale 1ns / 1ps
module oscillating_spring_damper_force #(
    parameter int FRAC_BITS = osdf_pkg::FRAC_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [osdf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [osdf_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             func,
    input  logic signed [31:0]               pos_a_x,
    input  logic signed [31:0]               pos_a_y,
    input  logic signed [31:0]               pos_b_x,
    input  logic signed [31:0]               pos_b_y,
    input  logic signed [31:0]               vel_a_x,
    input  logic signed [31:0]               vel_a_y,
    input  logic signed [31:0]               vel_b_x,
    input  logic signed [31:0]               vel_b_y,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [31:0]               force_x,
    output logic signed [31:0]               force_y,
    output logic                             nudged,
    output logic                             contracted,
    output logic [15:0]                      phase
);
    import osdf_pkg::*;

    // Coincident nodes get a direction of one tenth along x.
    localparam logic [32:0] NUDGE_DX = 33'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);

    typedef enum logic [3:0] {
        S_IDLE, S_SQX, S_SQY, S_SQRT, S_DIVX, S_DIVY, S_DOTX, S_DOTY,
        S_DOTT, S_FS, S_FD, S_FT, S_FTM, S_FX, S_FY, S_DONE
    } state_t;

    state_t      state_reg, state_next;
    logic        started_reg, started_next;
    logic [32:0] mdx_reg, mdx_next, mdy_reg, mdy_next;
    logic        sdx_reg, sdx_next, sdy_reg, sdy_next;
    logic [32:0] mdvx_reg, mdvx_next, mdvy_reg, mdvy_next;
    logic        sdvx_reg, sdvx_next, sdvy_reg, sdvy_next;
    logic        nud_reg, nud_next;
    logic [65:0] sum_reg, sum_next;
    logic [32:0] dist_reg, dist_next;
    logic [30:0] umx_reg, umx_next, umy_reg, umy_next;
    logic [33:0] dotm_reg, dotm_next;
    logic        dots_reg, dots_next;
    logic [33:0] vm_reg, vm_next;
    logic        vs_reg, vs_next;
    logic [41:0] fsm_reg, fsm_next, fdm_reg, fdm_next;
    logic        fss_reg, fss_next, fds_reg, fds_next;
    logic [43:0] ft_reg, ft_next, ftm_reg, ftm_next;
    logic        fts_reg, fts_next;
    logic [31:0] fx_reg, fx_next, fy_reg, fy_next;
    logic        ovalid_reg, ovalid_next;
    logic [31:0] ofx_reg, ofx_next, ofy_reg, ofy_next;
    logic        onud_reg, onud_next, ocon_reg, ocon_next;
    logic [15:0] ophase_reg, ophase_next;

    logic        accept;
    logic        tick;
    logic [32:0] dx, dy, dvx, dvy, dx_eff;
    logic        coincide;
    logic [65:0] term;
    logic [65:0] dmag;
    logic [30:0] rest;
    logic [33:0] v;
    logic [43:0] fs_s, fd_s;

    unit_req_t   req;
    unit_rsp_t   rsp;
    osc_t        osc;

    function automatic logic [31:0] sat_force(input logic [P_W-31:0] q, input logic neg);
        logic [31:0] r;
        if (neg)
        begin
            r = (q > (P_W-30)'(64'h8000_0000)) ? 32'h8000_0000 : (32'd0 - q[31:0]);
        end
        else
        begin
            r = (q > (P_W-30)'(64'h7FFF_FFFF)) ? 32'h7FFF_FFFF : q[31:0];
        end
        return r;
    endfunction

    osdf_osc u_osc (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .tick      (tick),
        .osc       (osc)
    );

    osdf_unit u_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign tick     = accept && !func;

    // Node differences, B minus A, at full 33-bit range.
    assign dx  = {pos_b_x[31], pos_b_x} - {pos_a_x[31], pos_a_x};
    assign dy  = {pos_b_y[31], pos_b_y} - {pos_a_y[31], pos_a_y};
    assign dvx = {vel_b_x[31], vel_b_x} - {vel_a_x[31], vel_a_x};
    assign dvy = {vel_b_y[31], vel_b_y} - {vel_a_y[31], vel_a_y};
    assign coincide = (dx == 33'd0) && (dy == 33'd0);
    assign dx_eff   = coincide ? NUDGE_DX : dx;

    assign term = {2'b00, rsp.res[63:0]};
    assign dmag = sum_reg[65] ? (66'd0 - sum_reg) : sum_reg;
    assign rest = osc.contracted ? osc.contract_length : osc.expand_length;
    assign v    = {1'b0, dist_reg} - {3'b000, rest};
    assign fs_s = fss_reg ? (44'd0 - {2'b00, fsm_reg}) : {2'b00, fsm_reg};
    assign fd_s = fds_reg ? (44'd0 - {2'b00, fdm_reg}) : {2'b00, fdm_reg};

    // Operands for the shared unit; each compute state starts it once.
    always_comb
    begin
        req       = '0;
        req.op    = OP_MUL;
        req.start = 1'b0;
        case (state_reg)
            S_SQX:  begin req.a = A_W'(mdx_reg);  req.b = mdx_reg; end
            S_SQY:  begin req.a = A_W'(mdy_reg);  req.b = mdy_reg; end
            S_SQRT: begin req.op = OP_SQRT; req.a = sum_reg; end
            S_DIVX: begin req.op = OP_DIV; req.a = A_W'(mdx_reg); req.b = dist_reg; end
            S_DIVY: begin req.op = OP_DIV; req.a = A_W'(mdy_reg); req.b = dist_reg; end
            S_DOTX: begin req.a = A_W'(mdvx_reg); req.b = B_W'(umx_reg); end
            S_DOTY: begin req.a = A_W'(mdvy_reg); req.b = B_W'(umy_reg); end
            S_FS:   begin req.a = A_W'(vm_reg);   req.b = B_W'(osc.stiffness); end
            S_FD:   begin req.a = A_W'(dotm_reg); req.b = B_W'(osc.damping); end
            S_FX:   begin req.a = A_W'(ftm_reg);  req.b = B_W'(umx_reg); end
            S_FY:   begin req.a = A_W'(ftm_reg);  req.b = B_W'(umy_reg); end
            default: ;
        endcase
        case (state_reg) inside
            S_SQX, S_SQY, S_SQRT, S_DIVX, S_DIVY, S_DOTX, S_DOTY, S_FS, S_FD, S_FX, S_FY:
                req.start = !started_reg;
            default: req.start = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        started_next = started_reg;
        mdx_next  = mdx_reg;   sdx_next  = sdx_reg;
        mdy_next  = mdy_reg;   sdy_next  = sdy_reg;
        mdvx_next = mdvx_reg;  sdvx_next = sdvx_reg;
        mdvy_next = mdvy_reg;  sdvy_next = sdvy_reg;
        nud_next  = nud_reg;   sum_next  = sum_reg;
        dist_next = dist_reg;  umx_next  = umx_reg;  umy_next = umy_reg;
        dotm_next = dotm_reg;  dots_next = dots_reg;
        vm_next   = vm_reg;    vs_next   = vs_reg;
        fsm_next  = fsm_reg;   fss_next  = fss_reg;
        fdm_next  = fdm_reg;   fds_next  = fds_reg;
        ft_next   = ft_reg;    ftm_next  = ftm_reg;  fts_next = fts_reg;
        fx_next   = fx_reg;    fy_next   = fy_reg;
        ovalid_next = ovalid_reg && !out_ready;
        ofx_next  = ofx_reg;   ofy_next  = ofy_reg;
        onud_next = onud_reg;  ocon_next = ocon_reg;  ophase_next = ophase_reg;

        if (req.start)
        begin
            started_next = 1'b1;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    fx_next  = 32'd0;
                    fy_next  = 32'd0;
                    nud_next = 1'b0;
                    if (!func)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        nud_next  = coincide;
                        sdx_next  = dx_eff[32];
                        mdx_next  = dx_eff[32] ? (33'd0 - dx_eff) : dx_eff;
                        sdy_next  = dy[32];
                        mdy_next  = dy[32] ? (33'd0 - dy) : dy;
                        sdvx_next = dvx[32];
                        mdvx_next = dvx[32] ? (33'd0 - dvx) : dvx;
                        sdvy_next = dvy[32];
                        mdvy_next = dvy[32] ? (33'd0 - dvy) : dvy;
                        state_next = S_SQX;
                    end
                end
            end
            S_SQX:
            begin
                if (rsp.done)
                begin
                    sum_next = rsp.res[65:0];
                    started_next = 1'b0;
                    state_next = S_SQY;
                end
            end
            S_SQY:
            begin
                if (rsp.done)
                begin
                    sum_next = sum_reg + rsp.res[65:0];
                    started_next = 1'b0;
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                if (rsp.done)
                begin
                    dist_next = rsp.res[32:0];
                    started_next = 1'b0;
                    state_next = S_DIVX;
                end
            end
            S_DIVX:
            begin
                if (rsp.done)
                begin
                    umx_next = rsp.res[30:0];
                    started_next = 1'b0;
                    state_next = S_DIVY;
                end
            end
            S_DIVY:
            begin
                if (rsp.done)
                begin
                    umy_next = rsp.res[30:0];
                    started_next = 1'b0;
                    state_next = S_DOTX;
                end
            end
            S_DOTX:
            begin
                if (rsp.done)
                begin
                    sum_next = (sdx_reg ^ sdvx_reg) ? (66'd0 - term) : term;
                    started_next = 1'b0;
                    state_next = S_DOTY;
                end
            end
            S_DOTY:
            begin
                if (rsp.done)
                begin
                    sum_next = (sdy_reg ^ sdvy_reg) ? (sum_reg - term) : (sum_reg + term);
                    started_next = 1'b0;
                    state_next = S_DOTT;
                end
            end
            S_DOTT:
            begin
                // Dot product truncated toward zero, and the spring stretch.
                dotm_next  = dmag[63:30];
                dots_next  = sum_reg[65];
                vm_next    = v[33] ? (34'd0 - v) : v;
                vs_next    = v[33];
                state_next = S_FS;
            end
            S_FS:
            begin
                if (rsp.done)
                begin
                    fsm_next = rsp.res[49:8];
                    fss_next = vs_reg;
                    started_next = 1'b0;
                    state_next = S_FD;
                end
            end
            S_FD:
            begin
                if (rsp.done)
                begin
                    fdm_next = rsp.res[49:8];
                    fds_next = dots_reg;
                    started_next = 1'b0;
                    state_next = S_FT;
                end
            end
            S_FT:
            begin
                ft_next    = fs_s + fd_s;
                state_next = S_FTM;
            end
            S_FTM:
            begin
                ftm_next   = ft_reg[43] ? (44'd0 - ft_reg) : ft_reg;
                fts_next   = ft_reg[43];
                state_next = S_FX;
            end
            S_FX:
            begin
                if (rsp.done)
                begin
                    fx_next = sat_force(rsp.res[P_W-1:30], fts_reg ^ sdx_reg);
                    started_next = 1'b0;
                    state_next = S_FY;
                end
            end
            S_FY:
            begin
                if (rsp.done)
                begin
                    fy_next = sat_force(rsp.res[P_W-1:30], fts_reg ^ sdy_reg);
                    started_next = 1'b0;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // Hand the word to the output register once it is free.
                if (!ovalid_reg || out_ready)
                begin
                    ovalid_next = 1'b1;
                    ofx_next    = fx_reg;
                    ofy_next    = fy_reg;
                    onud_next   = nud_reg;
                    ocon_next   = osc.contracted;
                    ophase_next = osc.phase;
                    state_next  = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            started_reg <= 1'b0;
            mdx_reg  <= '0;  sdx_reg  <= 1'b0;  mdy_reg  <= '0;  sdy_reg  <= 1'b0;
            mdvx_reg <= '0;  sdvx_reg <= 1'b0;  mdvy_reg <= '0;  sdvy_reg <= 1'b0;
            nud_reg  <= 1'b0; sum_reg <= '0;    dist_reg <= '0;
            umx_reg  <= '0;  umy_reg  <= '0;    dotm_reg <= '0;  dots_reg <= 1'b0;
            vm_reg   <= '0;  vs_reg   <= 1'b0;  fsm_reg  <= '0;  fss_reg  <= 1'b0;
            fdm_reg  <= '0;  fds_reg  <= 1'b0;  ft_reg   <= '0;  ftm_reg  <= '0;
            fts_reg  <= 1'b0; fx_reg  <= '0;    fy_reg   <= '0;
            ovalid_reg <= 1'b0;
            ofx_reg  <= '0;  ofy_reg  <= '0;    onud_reg <= 1'b0; ocon_reg <= 1'b0;
            ophase_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            started_reg <= started_next;
            mdx_reg  <= mdx_next;  sdx_reg  <= sdx_next;
            mdy_reg  <= mdy_next;  sdy_reg  <= sdy_next;
            mdvx_reg <= mdvx_next; sdvx_reg <= sdvx_next;
            mdvy_reg <= mdvy_next; sdvy_reg <= sdvy_next;
            nud_reg  <= nud_next;  sum_reg  <= sum_next;  dist_reg <= dist_next;
            umx_reg  <= umx_next;  umy_reg  <= umy_next;
            dotm_reg <= dotm_next; dots_reg <= dots_next;
            vm_reg   <= vm_next;   vs_reg   <= vs_next;
            fsm_reg  <= fsm_next;  fss_reg  <= fss_next;
            fdm_reg  <= fdm_next;  fds_reg  <= fds_next;
            ft_reg   <= ft_next;   ftm_reg  <= ftm_next;  fts_reg <= fts_next;
            fx_reg   <= fx_next;   fy_reg   <= fy_next;
            ovalid_reg <= ovalid_next;
            ofx_reg  <= ofx_next;  ofy_reg  <= ofy_next;
            onud_reg <= onud_next; ocon_reg <= ocon_next;
            ophase_reg <= ophase_next;
        end
    end

    assign out_valid  = ovalid_reg;
    assign force_x    = ofx_reg;
    assign force_y    = ofy_reg;
    assign nudged     = onud_reg;
    assign contracted = ocon_reg;
    assign phase      = ophase_reg;

`ifndef ASSERT_OFF
    // The shared unit is never left running while the block waits for a word.
    a_idle_unit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !rsp.busy)
        else $error("arithmetic unit busy while idle");

    // A nudge only happens with no y offset, so the y force must be zero.
    a_nudge_y: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && nudged) |-> (force_y == 32'sd0))
        else $error("nonzero y force on a nudged word");

    // A tick word skips the arithmetic and goes straight to the result.
    a_tick_path: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !func) |=> (state_reg == S_DONE))
        else $error("tick word did not go straight to the result");
`endif

endmodule

### test/tb_oscillating_spring_damper_force.sv
// Self-checking testbench for the oscillating spring-damper force block.
`timescale 1ns / 1ps
module tb_oscillating_spring_damper_force;
    import osdf_pkg::*;

    // A word that has been queued for the block, and the result that the
    // predictor expects back for it.
    typedef struct packed {
        logic        func;
        logic [31:0] pax, pay, pbx, pby, vax, vay, vbx, vby;
    } spring_word_t;

    typedef struct packed {
        logic [31:0] fx, fy;
        logic        nudged;
        logic        contracted;
        logic [15:0] phase;
    } force_word_t;

    localparam int NUDGE_DX = ((1 << FRAC_BITS_DEF) + 5) / 10;
    localparam longint CYCLE_LIMIT = 3000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic func = 1'b0;
    logic signed [31:0] pos_a_x = 0, pos_a_y = 0, pos_b_x = 0, pos_b_y = 0;
    logic signed [31:0] vel_a_x = 0, vel_a_y = 0, vel_b_x = 0, vel_b_y = 0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [31:0] force_x, force_y;
    logic nudged, contracted;
    logic [15:0] phase;

    oscillating_spring_damper_force uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .func(func),
        .pos_a_x(pos_a_x), .pos_a_y(pos_a_y), .pos_b_x(pos_b_x), .pos_b_y(pos_b_y),
        .vel_a_x(vel_a_x), .vel_a_y(vel_a_y), .vel_b_x(vel_b_x), .vel_b_y(vel_b_y),
        .out_valid(out_valid), .out_ready(out_ready),
        .force_x(force_x), .force_y(force_y), .nudged(nudged),
        .contracted(contracted), .phase(phase)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Predictor copy of the configuration and oscillator state.
    logic [15:0] m_clock_step, m_contract_time, m_stiff_coef, m_damp_coef, m_phase;
    logic [30:0] m_expand_len, m_contract_len;
    logic        m_contracted;

    spring_word_t pending_words[$];
    force_word_t  expected_forces[$];

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    logic hold_off_armed = 1'b0;
    logic hold_off_used = 1'b0;
    int  hold_off_cycles = 0;
    logic in_taken = 1'b0;
    int  mismatches = 0;
    int  words_checked = 0;
    int  nudges_seen = 0;
    longint cycle_count = 0;

    // Exact floor square root of a non-negative value below 2^68.
    function automatic logic [33:0] hyp_root(input logic [67:0] radicand);
        logic [33:0] root;
        logic [33:0] trial;
        root = '0;
        for (int k = 33; k >= 0; k--)
        begin
            trial = root | (34'd1 << k);
            if ({68'd0, trial} * {68'd0, trial} <= {68'd0, radicand})
                root = trial;
        end
        return root;
    endfunction

    // Shift right with truncation toward zero.
    function automatic logic signed [127:0] shr_to_zero(input logic signed [127:0] v,
                                                        input int s);
        logic signed [127:0] m;
        m = (v < 0) ? -v : v;
        m = m >>> s;
        return (v < 0) ? -m : m;
    endfunction

    // Product of total force and one unit component, truncated and saturated.
    function automatic logic [31:0] scale_force(input logic signed [127:0] total,
                                                input logic signed [127:0] unit_c);
        logic signed [127:0] p;
        p = shr_to_zero(total * unit_c, 30);
        if (p > 128'sd2147483647)
            return 32'h7FFF_FFFF;
        if (p < -128'sd2147483648)
            return 32'h8000_0000;
        return p[31:0];
    endfunction

    // Work out the result of one word and update the oscillator state.
    function automatic force_word_t predict_force(input spring_word_t w);
        force_word_t r;
        logic signed [127:0] dx, dy, dvx, dvy, ux, uy, dot, fs, fd, ft, span, rest;
        logic [16:0] sum;
        r = '0;
        if (w.func == 1'b0)
        begin
            sum = {1'b0, m_phase} + {1'b0, m_clock_step};
            m_phase = sum[16] ? 16'd0 : sum[15:0];
            m_contracted = (m_phase > m_contract_time);
        end
        else
        begin
            dx = $signed(w.pbx) - $signed(w.pax);
            dy = $signed(w.pby) - $signed(w.pay);
            dvx = $signed(w.vbx) - $signed(w.vax);
            dvy = $signed(w.vby) - $signed(w.vay);
            if (dx == 0 && dy == 0)
            begin
                dx = NUDGE_DX;
                r.nudged = 1'b1;
            end
            span = hyp_root(68'(dx * dx + dy * dy));
            if (span == 0)
                span = 1;
            ux = ((dx < 0 ? -dx : dx) <<< 30) / span;
            uy = ((dy < 0 ? -dy : dy) <<< 30) / span;
            if (dx < 0) ux = -ux;
            if (dy < 0) uy = -uy;
            dot = shr_to_zero(ux * dvx + uy * dvy, 30);
            rest = m_contracted ? m_contract_len : m_expand_len;
            fs = shr_to_zero((span - rest) * $signed({1'b0, m_stiff_coef}), 8);
            fd = shr_to_zero(dot * $signed({1'b0, m_damp_coef}), 8);
            ft = fs + fd;
            r.fx = scale_force(ft, ux);
            r.fy = scale_force(ft, uy);
        end
        r.contracted = m_contracted;
        r.phase = m_phase;
        return r;
    endfunction

    // Register write between phases; the block must be idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [30:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_CLOCK_START:     m_phase = val[15:0];
            REG_CLOCK_STEP:      m_clock_step = val[15:0];
            REG_CONTRACT_TIME:   m_contract_time = val[15:0];
            REG_EXPAND_LENGTH:   m_expand_len = val;
            REG_CONTRACT_LENGTH: m_contract_len = val;
            REG_STIFFNESS:       m_stiff_coef = val[15:0];
            REG_DAMPING:         m_damp_coef = val[15:0];
            default: ;
        endcase
    endtask

    // Wait until every queued word has been checked, then a short settle.
    task automatic drain;
        while (pending_words.size() != 0 || expected_forces.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic queue_word(input spring_word_t w);
        pending_words.insert(pending_words.size(), w);
    endtask

    function automatic logic [31:0] rand_coord(input int kind);
        case (kind)
            0: return $urandom();
            1: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
            default: return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
        endcase
    endfunction

    // Random word: mostly force requests at modest distances, with ticks mixed in.
    function automatic spring_word_t random_word;
        spring_word_t w;
        int kind;
        kind = $urandom_range(0, 9);
        w.func = ($urandom_range(0, 3) != 0);
        w.pax = rand_coord(kind % 3);
        w.pay = rand_coord(kind % 3);
        w.pbx = rand_coord(kind % 3);
        w.pby = rand_coord(kind % 3);
        w.vax = rand_coord((kind + 1) % 3);
        w.vay = rand_coord((kind + 1) % 3);
        w.vbx = rand_coord((kind + 1) % 3);
        w.vby = rand_coord((kind + 1) % 3);
        // Coincident nodes and nodes differing in one axis only.
        if (kind == 7)
        begin
            w.pbx = w.pax;
            w.pby = w.pay;
        end
        else if (kind == 8)
            w.pby = w.pay;
        return w;
    endfunction

    // Driver: offers the head of the pending queue, idling at random.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_taken)
            begin
                // Holding the offered word until the block takes it.
            end
            else if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                func <= pending_words[0].func;
                pos_a_x <= pending_words[0].pax;
                pos_a_y <= pending_words[0].pay;
                pos_b_x <= pending_words[0].pbx;
                pos_b_y <= pending_words[0].pby;
                vel_a_x <= pending_words[0].vax;
                vel_a_y <= pending_words[0].vay;
                vel_b_x <= pending_words[0].vbx;
                vel_b_y <= pending_words[0].vby;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Acceptance: the predictor runs when the block takes a word, and the
    // driver learns that the offered word is gone.
    always @(posedge clk)
    begin
        in_taken <= rst_n && in_valid && in_ready;
        if (rst_n && in_valid && in_ready)
            expected_forces.insert(expected_forces.size(),
                                   predict_force(pending_words.pop_front()));
    end

    // Receiver: random stalls, plus one long hold-off counted here.
    always @(negedge clk)
    begin
        if (hold_off_armed && !hold_off_used)
        begin
            hold_off_used <= 1'b1;
            hold_off_cycles <= 3000;
            out_ready <= 1'b0;
        end
        else if (hold_off_cycles > 0)
        begin
            hold_off_cycles <= hold_off_cycles - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Monitor: every accepted result is compared with the oldest expectation.
    always @(posedge clk)
    begin
        force_word_t exp_w;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_forces.size() == 0)
            begin
                $display("%0t: result with nothing expected: fx=%h fy=%h", $time,
                         force_x, force_y);
                mismatches++;
            end
            else
            begin
                exp_w = expected_forces.pop_front();
                words_checked++;
                if (exp_w.nudged)
                    nudges_seen++;
                if (force_x !== exp_w.fx)
                begin
                    $display("%0t: force_x expected %h actual %h", $time, exp_w.fx, force_x);
                    mismatches++;
                end
                if (force_y !== exp_w.fy)
                begin
                    $display("%0t: force_y expected %h actual %h", $time, exp_w.fy, force_y);
                    mismatches++;
                end
                if (nudged !== exp_w.nudged)
                begin
                    $display("%0t: nudged expected %b actual %b", $time, exp_w.nudged, nudged);
                    mismatches++;
                end
                if (contracted !== exp_w.contracted)
                begin
                    $display("%0t: contracted expected %b actual %b", $time,
                             exp_w.contracted, contracted);
                    mismatches++;
                end
                if (phase !== exp_w.phase)
                begin
                    $display("%0t: phase expected %h actual %h", $time, exp_w.phase, phase);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog on the cycle count.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     expected_forces.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        spring_word_t w;
        m_phase = 0;
        m_contracted = 0;
        m_clock_step = RST_CLOCK_STEP;
        m_contract_time = RST_CONTRACT_TIME;
        m_expand_len = RST_EXPAND_LENGTH;
        m_contract_len = RST_CONTRACT_LENGTH;
        m_stiff_coef = RST_STIFFNESS;
        m_damp_coef = RST_DAMPING;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part at reset settings: ticks, coincident nodes, field extremes.
        w = '0;
        queue_word(w);
        w.func = 1'b1;
        queue_word(w);
        w.pax = 32'h0001_0000; w.pbx = 32'h0001_0000; w.vbx = 32'h0003_0000;
        queue_word(w);
        w = '0; w.func = 1'b1;
        w.pax = 32'h8000_0000; w.pay = 32'h8000_0000;
        w.pbx = 32'h7FFF_FFFF; w.pby = 32'h7FFF_FFFF;
        w.vax = 32'h7FFF_FFFF; w.vay = 32'h8000_0000;
        w.vbx = 32'h8000_0000; w.vby = 32'h7FFF_FFFF;
        queue_word(w);
        w = '0; w.func = 1'b1;
        w.pax = 32'h7FFF_FFFF; w.pbx = 32'h8000_0000;
        w.vax = 32'hFFFF_FFFF; w.vby = 32'h7FFF_FFFF;
        queue_word(w);
        w = '0; w.func = 1'b1; w.pby = 32'hFFFF_FFFF; w.vay = 32'h8000_0000;
        queue_word(w);
        w = '0; w.func = 1'b1; w.pbx = 32'h0000_0001;
        queue_word(w);
        send_idle_pct = 30;
        recv_idle_pct = 54;
        drain();

        // Extreme register values, phase wrap and the contracted rest length.
        write_reg(REG_CLOCK_START, 31'h0000_FFFF);
        write_reg(REG_CLOCK_STEP, 31'h0000_FFFF);
        write_reg(REG_CONTRACT_TIME, 31'd0);
        write_reg(REG_EXPAND_LENGTH, 31'h7FFF_FFFF);
        write_reg(REG_CONTRACT_LENGTH, 31'd0);
        write_reg(REG_STIFFNESS, 31'h0000_FFFF);
        write_reg(REG_DAMPING, 31'h0000_FFFF);
        w = '0;
        queue_word(w);
        w.func = 1'b1; w.pbx = 32'h7FFF_FFFF; w.vbx = 32'h8000_0000;
        queue_word(w);
        drain();
        write_reg(REG_CLOCK_STEP, 31'd1);
        drain();
        w = '0;
        queue_word(w);
        w.func = 1'b1; w.pbx = 32'h8000_0000; w.vbx = 32'h7FFF_FFFF;
        queue_word(w);
        w.pbx = 32'h0; w.pby = 32'h0;
        queue_word(w);
        drain();

        // Random phases, each under its own register setting; the idle mix changes at phases 3 and 6.
        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph == 3)
            begin
                send_idle_pct = 54;
                recv_idle_pct = 30;
            end
            else if (ph == 6)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_reg(REG_CLOCK_START, 31'($urandom_range(0, 16'hFFFF)));
            write_reg(REG_CLOCK_STEP, (ph == 7) ? 31'd0
                                                : 31'($urandom_range(0, 16'h3FFF)));
            write_reg(REG_CONTRACT_TIME, 31'($urandom_range(0, 16'hFFFF)));
            write_reg(REG_EXPAND_LENGTH, (ph == 1) ? 31'h7FFF_FFFF
                                                   : 31'($urandom_range(0, 31'h00FF_FFFF)));
            write_reg(REG_CONTRACT_LENGTH, (ph == 2) ? 31'd0 : 31'($urandom()));
            write_reg(REG_STIFFNESS, (ph == 4) ? 31'd0 : 31'($urandom_range(0, 16'hFFFF)));
            write_reg(REG_DAMPING, (ph == 5) ? 31'h0000_FFFF
                                             : 31'($urandom_range(0, 16'hFFFF)));
            for (int i = 0; i < 200; i++)
                queue_word(random_word());
            // Starve the output for a while so the input side backs up.
            if (ph == 6)
                hold_off_armed = 1'b1;
            drain();
        end

        $display("Checked %0d words (%0d with coincident nodes) over eight random settings",
                 words_checked, nudges_seen);
        $display("plus directed extremes; %0d mismatches.", mismatches);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### filelist.f
src/osdf_pkg.sv
src/osdf_osc.sv
src/osdf_unit.sv
src/oscillating_spring_damper_force.sv
test/tb_oscillating_spring_damper_force.sv
